[src/irce_pkg.sv]
// Shared types and constants for the IR pulse/space carrier expander.
`timescale 1ns / 1ps

package irce_pkg;

    // Field widths
    localparam int DUR_W     = 32;
    localparam int CARRIER_W = 19;
    localparam int DUTY_W    = 7;
    localparam int WORD_W    = 16;

    // Register reset values
    localparam logic [CARRIER_W-1:0] CARRIER_RESET = 19'd38000;
    localparam logic [DUTY_W-1:0]    DUTY_RESET    = 7'd30;

    // Register decode on paddr[2]
    localparam logic REG_CARRIER = 1'b0;
    localparam logic REG_DUTY    = 1'b1;

    // Rounding to nearest for the divide by 1e6
    localparam int ROUND_HALF = 500000;
    // 1e6 = 2^6 * 15625: shift first, then divide by 15625
    localparam int SCALE_SHIFT = 6;
    localparam int DIV_W       = 14;
    localparam logic [DIV_W-1:0] SCALED_DIV = 14'd15625;
    // floor(2^30 / 15625), good for dividends below 2^30
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = 17;
    localparam logic [RECIP_W-1:0] RECIP = 17'd68719;

    // Item passed from the period pipeline to the frame stage
    typedef struct packed {
        logic [DUR_W-1:0] periods;
        logic             frame_start;
    } period_item_t;

endpackage

[src/irce_divider.sv]
// Period pipeline: duration * carrier, rounded divide by 1e6.
`timescale 1ns / 1ps

module irce_divider (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [irce_pkg::CARRIER_W-1:0]      carrier_hz,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [irce_pkg::DUR_W-1:0]          duration_us,
    input  logic                                frame_start,
    output logic                                out_valid,
    input  logic                                out_stall,
    output irce_pkg::period_item_t              out_item
);

    localparam int STAGES = 6;
    localparam int PROD_W = irce_pkg::DUR_W + irce_pkg::CARRIER_W;
    localparam int WORD_W = irce_pkg::WORD_W;
    localparam int HI_W   = PROD_W - irce_pkg::SCALE_SHIFT - WORD_W;
    localparam int X_W    = irce_pkg::RECIP_SHIFT;
    localparam int EST_W  = irce_pkg::RECIP_W;
    localparam int MUL_W  = X_W + EST_W;
    localparam int REM_W  = X_W + 1;
    localparam int DIV_W  = irce_pkg::DIV_W;

    // Stage valid bits and moves
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] move;
    logic              in_load;

    // Frame start rides along with each stage
    logic [STAGES-1:0] fs_reg;

    // Stage payloads
    logic [irce_pkg::DUR_W-1:0] s1_dur_reg;
    logic [PROD_W-1:0]          s2_prod_reg;
    logic [PROD_W-1:0]          s2_prod_next;
    logic [HI_W-1:0]            s3_hi_reg;
    logic [WORD_W-1:0]          s3_lo_reg;
    logic [EST_W-1:0]           s3_est_reg;
    logic [WORD_W-1:0]          s4_q1_reg;
    logic [X_W-1:0]             s4_x2_reg;
    logic [WORD_W-1:0]          s5_q1_reg;
    logic [X_W-1:0]             s5_x2_reg;
    logic [EST_W-1:0]           s5_est_reg;
    logic [irce_pkg::DUR_W-1:0] s6_periods_reg;

    // Bubble-collapsing flow control, last stage first
    always_comb
    begin
        move[STAGES-1] = valid_reg[STAGES-1] && !out_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            move[k] = valid_reg[k] && (!valid_reg[k+1] || move[k+1]);
        end
        in_stall = valid_reg[0] && !move[0];
        in_load  = in_valid && !in_stall;
        valid_next[0] = in_load || (valid_reg[0] && !move[0]);
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = move[k-1] || (valid_reg[k] && !move[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage 1 to 2: carrier multiply
    assign s2_prod_next = PROD_W'(s1_dur_reg) * PROD_W'(carrier_hz);

    // Stage 2 to 3: round, drop 2^6, estimate high quotient digit
    logic [PROD_W-1:0] rounded;
    logic [HI_W-1:0]   hi_part;
    logic [MUL_W-1:0]  est1_full;

    assign rounded   = s2_prod_reg + PROD_W'(irce_pkg::ROUND_HALF);
    assign hi_part   = rounded[PROD_W-1 -: HI_W];
    assign est1_full = MUL_W'(X_W'(hi_part)) * MUL_W'(irce_pkg::RECIP);

    // Stage 3 to 4: correct high digit, form low dividend
    logic [REM_W-1:0] rem1;
    logic             corr1;
    logic [REM_W-1:0] rem1_fix;
    logic [EST_W-1:0] q1;

    assign rem1     = REM_W'(s3_hi_reg)
                      - REM_W'(s3_est_reg) * REM_W'(irce_pkg::SCALED_DIV);
    assign corr1    = rem1 >= REM_W'(irce_pkg::SCALED_DIV);
    assign rem1_fix = corr1 ? rem1 - REM_W'(irce_pkg::SCALED_DIV) : rem1;
    assign q1       = s3_est_reg + EST_W'(corr1);

    // Stage 4 to 5: estimate low quotient digit
    logic [MUL_W-1:0] est2_full;

    assign est2_full = MUL_W'(s4_x2_reg) * MUL_W'(irce_pkg::RECIP);

    // Stage 5 to 6: correct low digit
    logic [REM_W-1:0] rem2;
    logic             corr2;
    logic [EST_W-1:0] q2;

    assign rem2  = REM_W'(s5_x2_reg)
                   - REM_W'(s5_est_reg) * REM_W'(irce_pkg::SCALED_DIV);
    assign corr2 = rem2 >= REM_W'(irce_pkg::SCALED_DIV);
    assign q2    = s5_est_reg + EST_W'(corr2);

    // Payload registers, loaded as items move in
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            s1_dur_reg <= duration_us;
            fs_reg[0]  <= frame_start;
        end
        if (move[0])
        begin
            s2_prod_reg <= s2_prod_next;
            fs_reg[1]   <= fs_reg[0];
        end
        if (move[1])
        begin
            s3_hi_reg  <= hi_part;
            s3_lo_reg  <= rounded[irce_pkg::SCALE_SHIFT +: WORD_W];
            s3_est_reg <= est1_full[X_W +: EST_W];
            fs_reg[2]  <= fs_reg[1];
        end
        if (move[2])
        begin
            s4_q1_reg <= q1[WORD_W-1:0];
            s4_x2_reg <= {rem1_fix[DIV_W-1:0], s3_lo_reg};
            fs_reg[3] <= fs_reg[2];
        end
        if (move[3])
        begin
            s5_q1_reg  <= s4_q1_reg;
            s5_x2_reg  <= s4_x2_reg;
            s5_est_reg <= est2_full[X_W +: EST_W];
            fs_reg[4]  <= fs_reg[3];
        end
        if (move[4])
        begin
            s6_periods_reg <= {s5_q1_reg, q2[WORD_W-1:0]};
            fs_reg[5]      <= fs_reg[4];
        end
    end

    assign out_valid            = valid_reg[STAGES-1];
    assign out_item.periods     = s6_periods_reg;
    assign out_item.frame_start = fs_reg[STAGES-1];

endmodule

[src/irce_frame.sv]
// Frame stage: phase, buffer accounting, overflow and the result register.
`timescale 1ns / 1ps

module irce_frame #(
    parameter int BUFFER_WORDS = 40000
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [irce_pkg::DUTY_W-1:0]      duty_percent,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  irce_pkg::period_item_t           in_item,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [irce_pkg::WORD_W-1:0]      spi_word,
    output logic [irce_pkg::WORD_W-1:0]      repeat_count,
    output logic [irce_pkg::WORD_W-1:0]      buffer_offset,
    output logic                             overflow
);

    localparam int WORD_W = irce_pkg::WORD_W;
    localparam int SUM_W  = irce_pkg::DUR_W + 1;
    // x/100 as (x * 5243) >> 19, exact for x below 2048
    localparam int TOP_W   = 5;
    localparam int SCALE_W = 24;

    // Frame state
    logic              phase_reg, phase_next;
    logic [WORD_W-1:0] used_reg, used_next;
    logic              failed_reg, failed_next;

    // Result register
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [WORD_W-1:0] count_reg, count_next;
    logic [WORD_W-1:0] offset_reg, offset_next;
    logic              ovf_reg, ovf_next;

    logic take;
    logic hold;

    // Pulse mask from duty: top = duty*15/100, mask of top+1 ones, at most 16
    logic [SCALE_W-1:0] duty_scaled;
    logic [TOP_W-1:0]   mask_top;
    logic [WORD_W-1:0]  pulse_mask;

    assign duty_scaled = SCALE_W'(duty_percent) * SCALE_W'(15) * SCALE_W'(5243);
    assign mask_top    = duty_scaled[19 +: TOP_W];

    always_comb
    begin
        if (mask_top >= TOP_W'(15))
        begin
            pulse_mask = '1;
        end
        else
        begin
            pulse_mask = WORD_W'((17'd1 << (mask_top + TOP_W'(1))) - 17'd1);
        end
    end

    // Handshake: result register frees up when taken
    assign hold     = out_valid_reg && out_stall;
    assign in_stall = hold;
    assign take     = in_valid && !hold;

    // Per-item state update
    logic              cur_phase;
    logic [WORD_W-1:0] cur_used;
    logic              cur_failed;
    logic [SUM_W-1:0]  run_end;
    logic              limit_hit;

    always_comb
    begin
        cur_phase  = in_item.frame_start ? 1'b0 : phase_reg;
        cur_used   = in_item.frame_start ? '0 : used_reg;
        cur_failed = in_item.frame_start ? 1'b0 : failed_reg;
        run_end    = SUM_W'(cur_used) + SUM_W'(in_item.periods);
        limit_hit  = run_end >= SUM_W'(BUFFER_WORDS);

        phase_next  = phase_reg;
        used_next   = used_reg;
        failed_next = failed_reg;
        word_next   = word_reg;
        count_next  = count_reg;
        offset_next = offset_reg;
        ovf_next    = ovf_reg;

        if (take)
        begin
            phase_next  = !cur_phase;
            used_next   = cur_used;
            failed_next = cur_failed;
            count_next  = '0;
            if (!cur_failed)
            begin
                if (limit_hit)
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    count_next = in_item.periods[WORD_W-1:0];
                    used_next  = run_end[WORD_W-1:0];
                end
            end
            word_next   = cur_phase ? '0 : pulse_mask;
            offset_next = cur_used;
            ovf_next    = failed_next;
        end

        out_valid_next = take || hold;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
            used_reg      <= '0;
            failed_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            used_reg      <= used_next;
            failed_reg    <= failed_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        word_reg   <= word_next;
        count_reg  <= count_next;
        offset_reg <= offset_next;
        ovf_reg    <= ovf_next;
    end

    assign out_valid     = out_valid_reg;
    assign spi_word      = word_reg;
    assign repeat_count  = count_reg;
    assign buffer_offset = offset_reg;
    assign overflow      = ovf_reg;

endmodule

[src/ir_pulse_space_carrier_expander.sv]
// Top level of the IR pulse/space carrier expander with its register port.
`timescale 1ns / 1ps

// Turns IR pulse/space durations (us) into SPI carrier runs: one item in,
// one result out, one item per clock sustained while out_stall is low. The
// six-stage period pipeline (carrier multiply and a rounded divide by 1e6
// done as two reciprocal digits) holds up to six items in flight and feeds
// the frame stage, which keeps the running buffer count, phase and sticky
// overflow, updates them once per item and registers the result. Pipeline
// bubbles collapse, so items keep entering while a result waits in the
// output register. Registers: carrier_hz at 0x0 (a write of 0 is ignored),
// duty_percent at 0x4; write them only while idle.

module ir_pulse_space_carrier_expander #(
    parameter int BUFFER_WORDS = 40000
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // Input items
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [irce_pkg::DUR_W-1:0]    duration_us,
    input  logic                          frame_start,
    // Result items
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [irce_pkg::WORD_W-1:0]   spi_word,
    output logic [irce_pkg::WORD_W-1:0]   repeat_count,
    output logic [irce_pkg::WORD_W-1:0]   buffer_offset,
    output logic                          overflow
);

    localparam int CARRIER_W = irce_pkg::CARRIER_W;
    localparam int DUTY_W    = irce_pkg::DUTY_W;

    // Configuration registers
    logic [CARRIER_W-1:0] carrier_reg, carrier_next;
    logic [DUTY_W-1:0]    duty_reg, duty_next;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        carrier_next = carrier_reg;
        duty_next    = duty_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                irce_pkg::REG_CARRIER:
                begin
                    if (pwdata[CARRIER_W-1:0] != '0)
                    begin
                        carrier_next = pwdata[CARRIER_W-1:0];
                    end
                end
                irce_pkg::REG_DUTY:
                begin
                    duty_next = pwdata[DUTY_W-1:0];
                end
                default:
                begin
                    carrier_next = carrier_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_reg <= irce_pkg::CARRIER_RESET;
            duty_reg    <= irce_pkg::DUTY_RESET;
        end
        else
        begin
            carrier_reg <= carrier_next;
            duty_reg    <= duty_next;
        end
    end

    // Register read back
    assign prdata = (paddr[2] == irce_pkg::REG_DUTY) ? 32'(duty_reg) : 32'(carrier_reg);

    // Period pipeline to frame stage
    logic                   mid_valid;
    logic                   mid_stall;
    irce_pkg::period_item_t mid_item;

    irce_divider u_divider (
        .clk         (clk),
        .rst_n       (rst_n),
        .carrier_hz  (carrier_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .duration_us (duration_us),
        .frame_start (frame_start),
        .out_valid   (mid_valid),
        .out_stall   (mid_stall),
        .out_item    (mid_item)
    );

    irce_frame #(
        .BUFFER_WORDS (BUFFER_WORDS)
    ) u_frame (
        .clk           (clk),
        .rst_n         (rst_n),
        .duty_percent  (duty_reg),
        .in_valid      (mid_valid),
        .in_stall      (mid_stall),
        .in_item       (mid_item),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .spi_word      (spi_word),
        .repeat_count  (repeat_count),
        .buffer_offset (buffer_offset),
        .overflow      (overflow)
    );

endmodule

[src/irce_checker.sv]
// Port-level assertions for the carrier expander, bound to the top level.
`timescale 1ns / 1ps

module irce_checker #(
    parameter int BUFFER_WORDS = 40000
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [irce_pkg::WORD_W-1:0]   spi_word,
    input logic [irce_pkg::WORD_W-1:0]   repeat_count,
    input logic [irce_pkg::WORD_W-1:0]   buffer_offset,
    input logic                          overflow
);

    localparam int WORD_W = irce_pkg::WORD_W;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(spi_word)
            && $stable(repeat_count) && $stable(buffer_offset) && $stable(overflow))
        else $error("result changed while stalled");

    // A failed frame places no words
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> repeat_count == '0)
        else $error("overflow result with nonzero repeat count");

    // A placed run ends below the buffer limit
    a_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !overflow
            |-> ({1'b0, buffer_offset} + {1'b0, repeat_count}) < (WORD_W+1)'(BUFFER_WORDS))
        else $error("run exceeds buffer limit");

    // The word is a low run of ones or zero
    a_word_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (spi_word & (spi_word + WORD_W'(1))) == '0)
        else $error("spi word is not a low mask");

endmodule

bind ir_pulse_space_carrier_expander irce_checker #(
    .BUFFER_WORDS (BUFFER_WORDS)
) u_irce_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .spi_word      (spi_word),
    .repeat_count  (repeat_count),
    .buffer_offset (buffer_offset),
    .overflow      (overflow)
);
